/* rtl/core/baro_temp_pressure_compensation_assert.svh */
// ----------------------------------------------------------------------------
// Barometric compensation assertion macros
// Shared concurrent check forms used by the compensation RTL.
// ----------------------------------------------------------------------------
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define BTPC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("btpc check failed");

// next-cycle implication, sampled on clk, off during rst
`define BTPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("btpc check failed");

`endif

/* rtl/core/btpc_pkg.sv */
// ----------------------------------------------------------------------------
// Barometric compensation package
// Widths, constants and register indexes of the compensation pipeline.
// ----------------------------------------------------------------------------
package btpc_pkg;

  localparam int DW      = 32;
  localparam int NUM_REG = 5;
  localparam int ADDR_W  = 5;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_AC1_AC2 = 3'd0;
  localparam logic [2:0] REG_AC3_AC4 = 3'd1;
  localparam logic [2:0] REG_AC5_AC6 = 3'd2;
  localparam logic [2:0] REG_B1_B2   = 3'd3;
  localparam logic [2:0] REG_MC_MD   = 3'd4;

  // compensation constants
  localparam logic [31:0] B6_OFS  = 32'd4000;
  localparam logic [31:0] X1_MUL  = 32'd3038;
  localparam logic [31:0] X2_MUL  = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] PR_OFS  = 32'd3791;
  localparam logic [31:0] B7_MUL  = 32'd50000;
  localparam logic [31:0] B4_OFS  = 32'd32768;

  localparam logic [17:0] P_MAX = 18'h3FFFF;

endpackage

/* rtl/core/baro_temp_pressure_compensation.sv */
// ----------------------------------------------------------------------------
// Barometric temperature and pressure compensation
// Fixed-point compensation pipeline with two pipelined dividers.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while the output is not stalled; the whole pipeline advances together.
// A stalled output freezes every stage, so nothing is lost or repeated.
// Reset: synchronous rst clears all valid bits and the calibration registers.
// The two 32-stage dividers set the depth.
module baro_temp_pressure_compensation import btpc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // raw_temperature [15:0], raw_pressure [31:16]
  input  logic [31:0]       s_tdata,
  input  logic              s_tvalid,
  output logic              s_tready,
  // temperature_tenths [15:0], pressure_pa [33:16], zero pad [39:34]
  output logic [39:0]       m_tdata,
  // divide_error [0]
  output logic [0:0]        m_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  `include "baro_temp_pressure_compensation_assert.svh"

  localparam int D1_SIDE = 50;
  localparam int D2_SIDE = 18;

  logic        adv;
  logic [31:0] cal [NUM_REG];
  logic [2:0]  reg_idx;

  // calibration register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REG; i++) cal[i] <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_AC1_AC2: cal[0] <= pwdata;
        REG_AC3_AC4: cal[1] <= pwdata;
        REG_AC5_AC6: cal[2] <= pwdata;
        REG_B1_B2:   cal[3] <= pwdata;
        REG_MC_MD:   cal[4] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_AC1_AC2: prdata = cal[0];
      REG_AC3_AC4: prdata = cal[1];
      REG_AC5_AC6: prdata = cal[2];
      REG_B1_B2:   prdata = cal[3];
      REG_MC_MD:   prdata = cal[4];
      default:     prdata = '0;
    endcase
  end

  // coefficients extended to 32 bits
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = {{16{cal[0][31]}}, cal[0][31:16]};
  assign ac2 = {{16{cal[0][15]}}, cal[0][15:0]};
  assign ac3 = {{16{cal[1][31]}}, cal[1][31:16]};
  assign ac4 = {16'd0, cal[1][15:0]};
  assign ac5 = {16'd0, cal[2][31:16]};
  assign ac6 = {16'd0, cal[2][15:0]};
  assign b1  = {{16{cal[3][31]}}, cal[3][31:16]};
  assign b2  = {{16{cal[3][15]}}, cal[3][15:0]};
  assign mc  = {{16{cal[4][31]}}, cal[4][31:16]};
  assign md  = {{16{cal[4][15]}}, cal[4][15:0]};

  // whole pipeline moves when the output register is free or drained
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // stage 1: input register
  logic        s1_v;
  logic [15:0] s1_ut, s1_up;
  // stage 2: temperature product
  logic        s2_v;
  logic [31:0] s2_prod;
  logic [15:0] s2_up;
  // stage 3: divider operands
  logic        s3_v, s3_neg, s3_err;
  logic [31:0] s3_ua, s3_ub, s3_x1;
  logic [15:0] s3_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else if (adv) begin
      s1_v <= s_tvalid;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  logic [31:0] x1_t, den_t, num_t;
  assign x1_t  = $signed(s2_prod) >>> 15;
  assign den_t = x1_t + md;
  assign num_t = mc << 11;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ut   <= s_tdata[15:0];
      s1_up   <= s_tdata[31:16];
      s2_prod <= ({16'd0, s1_ut} - ac6) * ac5;
      s2_up   <= s1_up;
      s3_ua   <= num_t[31] ? 32'd0 - num_t : num_t;
      s3_ub   <= den_t[31] ? 32'd0 - den_t : den_t;
      s3_neg  <= num_t[31] ^ den_t[31];
      s3_err  <= den_t == 32'd0;
      s3_x1   <= x1_t;
      s3_up   <= s2_up;
    end
  end

  // temperature divider
  logic               d1_v;
  logic [31:0]        d1_q;
  logic [D1_SIDE-1:0] d1_side;
  logic [31:0]        d1_x1;
  logic [15:0]        d1_up;
  logic               d1_neg, d1_err;

  btpc_div #(.SIDE_W(D1_SIDE)) u_div_t (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s3_v),
    .dividend  (s3_ua),
    .divisor   (s3_ub),
    .side_in   ({s3_err, s3_neg, s3_up, s3_x1}),
    .out_valid (d1_v),
    .quotient  (d1_q),
    .side_out  (d1_side)
  );
  assign {d1_err, d1_neg, d1_up, d1_x1} = d1_side;

  // stage 4: b5, temperature result, b6
  logic [31:0] b5, t_raw;
  logic [15:0] t_sat;
  assign b5    = d1_x1 + (d1_neg ? 32'd0 - d1_q : d1_q);
  assign t_raw = $signed(b5 + 32'd8) >>> 4;
  always_comb begin
    if ($signed(t_raw) > 32'sd32767)       t_sat = 16'h7FFF;
    else if ($signed(t_raw) < -32'sd32768) t_sat = 16'h8000;
    else                                   t_sat = t_raw[15:0];
  end

  logic        s4_v, s5_v, s6_v, s7_v, s8_v, s9_v;
  logic [31:0] s4_b6;
  logic [15:0] s4_t, s5_t, s6_t, s7_t, s8_t, s9_t;
  logic [15:0] s4_up, s5_up, s6_up, s7_up;
  logic        s4_err, s5_err, s6_err, s7_err, s8_err, s9_err;
  logic [31:0] s5_sqp, s5_a2p, s5_a3p;
  logic [31:0] s6_b2p, s6_b1p, s6_x2a, s6_x1b;
  logic [31:0] s7_b3, s7_b4m;
  logic [31:0] s8_b4p, s8_b7;
  logic [31:0] s9_num, s9_b4;
  logic        s9_big;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
      s7_v <= 1'b0;
      s8_v <= 1'b0;
      s9_v <= 1'b0;
    end else if (adv) begin
      s4_v <= d1_v;
      s5_v <= s4_v;
      s6_v <= s5_v;
      s7_v <= s6_v;
      s8_v <= s7_v;
      s9_v <= s8_v;
    end
  end

  // stage 6, 7 and 9 combinational terms
  logic [31:0] sq, x1a, x3a, b3n, b3, x2b, x3b, b4, b7;
  assign sq  = $signed(s5_sqp) >>> 12;
  assign x1a = $signed(s6_b2p) >>> 11;
  assign x3a = x1a + s6_x2a;
  assign b3n = (ac1 << 2) + x3a + 32'd2;
  assign b3  = b3n[31] ? 32'($signed(b3n + 32'd3) >>> 2) : 32'($signed(b3n) >>> 2);
  assign x2b = $signed(s6_b1p) >>> 16;
  assign x3b = $signed(s6_x1b + x2b + 32'd2) >>> 2;
  assign b4  = s8_b4p >> 15;
  assign b7  = s8_b7;

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 4
      s4_b6  <= b5 - B6_OFS;
      s4_t   <= t_sat;
      s4_up  <= d1_up;
      s4_err <= d1_err;
      // stage 5: products of b6
      s5_sqp <= s4_b6 * s4_b6;
      s5_a2p <= ac2 * s4_b6;
      s5_a3p <= ac3 * s4_b6;
      s5_t   <= s4_t;
      s5_up  <= s4_up;
      s5_err <= s4_err;
      // stage 6: products of sq
      s6_b2p <= b2 * sq;
      s6_b1p <= b1 * sq;
      s6_x2a <= $signed(s5_a2p) >>> 11;
      s6_x1b <= $signed(s5_a3p) >>> 13;
      s6_t   <= s5_t;
      s6_up  <= s5_up;
      s6_err <= s5_err;
      // stage 7: b3 and b4 factor
      s7_b3  <= b3;
      s7_b4m <= x3b + B4_OFS;
      s7_t   <= s6_t;
      s7_up  <= s6_up;
      s7_err <= s6_err;
      // stage 8: b4 and b7 products
      s8_b4p <= ac4 * s7_b4m;
      s8_b7  <= ({16'd0, s7_up} - s7_b3) * B7_MUL;
      s8_t   <= s7_t;
      s8_err <= s7_err;
      // stage 9: divider operands
      s9_b4  <= b4;
      s9_num <= b7[31] ? b7 : b7 << 1;
      s9_big <= b7[31];
      s9_err <= s8_err || (b4 == 32'd0);
      s9_t   <= s8_t;
    end
  end

  // pressure divider
  logic               d2_v;
  logic [31:0]        d2_q;
  logic [D2_SIDE-1:0] d2_side;
  logic [15:0]        d2_t;
  logic               d2_big, d2_err;

  btpc_div #(.SIDE_W(D2_SIDE)) u_div_p (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s9_v),
    .dividend  (s9_num),
    .divisor   (s9_b4),
    .side_in   ({s9_err, s9_big, s9_t}),
    .out_valid (d2_v),
    .quotient  (d2_q),
    .side_out  (d2_side)
  );
  assign {d2_err, d2_big, d2_t} = d2_side;

  // stages 10 to 12: pressure correction polynomial
  logic        s10_v, s11_v, s12_v;
  logic [31:0] s10_p, s11_p, s12_p;
  logic [31:0] s11_m1, s11_m2, s12_m3, s12_x2;
  logic [15:0] s10_t, s11_t, s12_t;
  logic        s10_err, s11_err, s12_err;
  logic [31:0] p8;

  assign p8 = $signed(s10_p) >>> 8;

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_v <= 1'b0;
      s11_v <= 1'b0;
      s12_v <= 1'b0;
    end else if (adv) begin
      s10_v <= d2_v;
      s11_v <= s10_v;
      s12_v <= s11_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s10_p   <= d2_big ? d2_q << 1 : d2_q;
      s10_t   <= d2_t;
      s10_err <= d2_err;
      s11_m1  <= p8 * p8;
      s11_m2  <= X2_MUL * s10_p;
      s11_p   <= s10_p;
      s11_t   <= s10_t;
      s11_err <= s10_err;
      s12_m3  <= s11_m1 * X1_MUL;
      s12_x2  <= $signed(s11_m2) >>> 16;
      s12_p   <= s11_p;
      s12_t   <= s11_t;
      s12_err <= s11_err;
    end
  end

  // final sum, saturation, output register
  logic [31:0] x1c, pr;
  logic [17:0] p_sat;
  assign x1c = $signed(s12_m3) >>> 16;
  assign pr  = s12_p + 32'($signed(x1c + s12_x2 + PR_OFS) >>> 4);
  always_comb begin
    if (pr[31])                    p_sat = '0;
    else if (pr > {14'd0, P_MAX})  p_sat = P_MAX;
    else                           p_sat = pr[17:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= s12_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata    <= s12_err ? 40'd0 : {6'd0, p_sat, s12_t};
      m_tuser[0] <= s12_err;
    end
  end

  // checks
  `BTPC_ASSERT_SAME(a_err_zero, m_tvalid && m_tuser[0], m_tdata == 40'd0)
  `BTPC_ASSERT_SAME(a_den_err, s3_v && s3_err, s3_ub == 32'd0)
  `BTPC_ASSERT_NEXT(a_stall_hold, !s_tready, $stable(s12_v) && $stable(s12_p) && $stable(d2_v))
  `BTPC_ASSERT_SAME(a_b4_err, s9_v && (s9_b4 == 32'd0), s9_err)

endmodule

/* rtl/core/btpc_div.sv */
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per stage, side payload rides along.
// ----------------------------------------------------------------------------
module btpc_div import btpc_pkg::*; #(
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DW-1:0]     dividend,
  input  logic [DW-1:0]     divisor,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [DW-1:0]     quotient,
  output logic [SIDE_W-1:0] side_out
);

  logic [DW-1:0]     vld;
  logic [DW-1:0]     rem  [DW];
  logic [DW-1:0]     quo  [DW];
  logic [DW-1:0]     dsr  [DW];
  logic [SIDE_W-1:0] side [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [DW-1:0] quo_in;
    logic [DW-1:0] dsr_in;
    logic [SIDE_W-1:0] side_i;
    logic          vld_in;
    logic [DW:0]   trial;
    logic          fit;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = dividend;
      assign dsr_in = divisor;
      assign side_i = side_in;
      assign vld_in = in_valid;
    end else begin : g_next
      assign rem_in = rem[k-1];
      assign quo_in = quo[k-1];
      assign dsr_in = dsr[k-1];
      assign side_i = side[k-1];
      assign vld_in = vld[k-1];
    end

    // shift in next dividend bit and try a subtract
    assign trial = {rem_in, quo_in[DW-1]};
    assign fit   = trial >= {1'b0, dsr_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= fit ? DW'(trial - {1'b0, dsr_in}) : trial[DW-1:0];
        quo[k]  <= {quo_in[DW-2:0], fit};
        dsr[k]  <= dsr_in;
        side[k] <= side_i;
      end
    end
  end

  assign out_valid = vld[DW-1];
  assign quotient  = quo[DW-1];
  assign side_out  = side[DW-1];

endmodule

/* tb/baro_temp_pressure_compensation_test.sv */
// ----------------------------------------------------------------------------
// Barometric compensation testbench
// Loads several calibration sets over the register port. Streams raw
// temperature and pressure readings through the block with random idle and
// stall patterns. Checks every output beat against a local copy of the
// integer compensation.
// ----------------------------------------------------------------------------
import btpc_pkg::*;

typedef struct packed {
  logic [15:0] temperature;
  logic [17:0] pressure;
  logic        div_err;
} baro_result_t;

class baro_checker;
  bit [31:0]    cal [NUM_REG];
  baro_result_t pending [$];
  int           mismatches;

  function new();
    foreach (cal[i]) cal[i] = '0;
    mismatches = 0;
  endfunction

  static function bit [31:0] asr(bit [31:0] v, int s);
    return $signed(v) >>> s;
  endfunction

  static function bit [31:0] sext(bit [15:0] h);
    return {{16{h[15]}}, h};
  endfunction

  // signed divide, truncating toward zero
  static function bit [31:0] sdiv(bit [31:0] a, bit [31:0] b);
    bit [31:0] ua, ub, q;
    ua = a[31] ? 32'd0 - a : a;
    ub = b[31] ? 32'd0 - b : b;
    q  = ua / ub;
    return (a[31] != b[31]) ? 32'd0 - q : q;
  endfunction

  function baro_result_t compensate(bit [15:0] raw_t, bit [15:0] raw_p);
    bit [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
    bit [31:0] x1, x2, x3, b3, b4, b5, b6, b7, p, sq, den, pr, t;
    int ts, ps;
    baro_result_t r;
    ac1 = sext(cal[REG_AC1_AC2][31:16]); ac2 = sext(cal[REG_AC1_AC2][15:0]);
    ac3 = sext(cal[REG_AC3_AC4][31:16]); ac4 = {16'd0, cal[REG_AC3_AC4][15:0]};
    ac5 = {16'd0, cal[REG_AC5_AC6][31:16]}; ac6 = {16'd0, cal[REG_AC5_AC6][15:0]};
    b1 = sext(cal[REG_B1_B2][31:16]); b2 = sext(cal[REG_B1_B2][15:0]);
    mc = sext(cal[REG_MC_MD][31:16]); md = sext(cal[REG_MC_MD][15:0]);
    ut = {16'd0, raw_t};
    up = {16'd0, raw_p};
    r = '{temperature: '0, pressure: '0, div_err: 1'b1};
    // temperature
    x1  = asr((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) return r;
    x2 = sdiv(mc << 11, den);
    b5 = x1 + x2;
    t  = asr(b5 + 32'd8, 4);
    // pressure
    b6 = b5 - B6_OFS;
    sq = asr(b6 * b6, 12);
    x1 = asr(b2 * sq, 11);
    x2 = asr(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = sdiv(ac1 * 32'd4 + x3 + 32'd2, 32'd4);
    x1 = asr(ac3 * b6, 13);
    x2 = asr(b1 * sq, 16);
    x3 = asr(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + B4_OFS)) >> 15;
    if (b4 == 0) return r;
    b7 = (up - b3) * B7_MUL;
    if (b7 < 32'h8000_0000) p = (b7 * 32'd2) / b4;
    else p = (b7 / b4) * 32'd2;
    x1 = asr(p, 8) * asr(p, 8);
    x1 = asr(x1 * X1_MUL, 16);
    x2 = asr(X2_MUL * p, 16);
    pr = p + asr(x1 + x2 + PR_OFS, 4);
    // saturate to the output ranges
    ts = $signed(t);
    if (ts > 32767) ts = 32767;
    if (ts < -32768) ts = -32768;
    ps = $signed(pr);
    if (ps > 262143) ps = 262143;
    if (ps < 0) ps = 0;
    r.temperature = ts[15:0];
    r.pressure    = ps[17:0];
    r.div_err     = 1'b0;
    return r;
  endfunction

  function void note_reading(bit [15:0] raw_t, bit [15:0] raw_p);
    pending.push_back(compensate(raw_t, raw_p));
  endfunction

  function void check_output(baro_result_t got);
    baro_result_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected output beat: %h", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected t=%0d p=%0d e=%b, got t=%0d p=%0d e=%b",
                 $signed(want.temperature), want.pressure, want.div_err,
                 $signed(got.temperature), got.pressure, got.div_err);
    end
  endfunction
endclass

module baro_temp_pressure_compensation_test;
  logic              clk;
  logic              rst;
  logic [31:0]       s_tdata;
  logic              s_tvalid;
  logic              s_tready;
  logic [39:0]       m_tdata;
  logic [0:0]        m_tuser;
  logic              m_tvalid;
  logic              m_tready;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  baro_checker checker_h = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  baro_temp_pressure_compensation dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // record accepted input beats and check output beats
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      checker_h.note_reading(s_tdata[15:0], s_tdata[31:16]);
    if (!rst && m_tvalid && m_tready)
      checker_h.check_output('{temperature: m_tdata[15:0],
                               pressure: m_tdata[33:16], div_err: m_tuser[0]});
  end

  // random receiver back-pressure
  always @(posedge clk)
    m_tready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic write_reg(int idx, bit [31:0] value);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_W'(4 * idx); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    checker_h.cal[idx] = value;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_reading(bit [15:0] raw_t, bit [15:0] raw_p);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {raw_p, raw_t};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (checker_h.pending.size() != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  // calibration word from two halves, with optional random jitter
  function automatic bit [31:0] pack_cal(bit [15:0] hi, bit [15:0] lo, bit jitter);
    if (jitter) begin
      hi = hi + 16'($urandom_range(64)) - 16'd32;
      lo = lo + 16'($urandom_range(64)) - 16'd32;
    end
    return {hi, lo};
  endfunction

  task automatic load_cal(int kind);
    bit [31:0] w [NUM_REG];
    bit j;
    j = (kind == 4);
    case (kind)
      1: foreach (w[i]) w[i] = 32'h0;              // temperature divisor zero
      2: foreach (w[i]) w[i] = 32'hFFFF_FFFF;
      5: foreach (w[i]) w[i] = $urandom;
      default: begin
        // typical datasheet calibration
        w[REG_AC1_AC2] = pack_cal(16'd408, -16'sd72, j);
        w[REG_AC3_AC4] = pack_cal(-16'sd14383, 16'd32741, j);
        w[REG_AC5_AC6] = pack_cal(16'd32757, 16'd23153, j);
        w[REG_B1_B2]   = pack_cal(16'd6190, 16'd4, j);
        w[REG_MC_MD]   = pack_cal(-16'sd8711, 16'd2868, j);
        // pressure divisor forced to zero
        if (kind == 3) w[REG_AC3_AC4][15:0] = 16'd0;
      end
    endcase
    for (int i = 0; i < NUM_REG; i++) write_reg(i, w[i]);
  endtask

  initial begin
    bit [15:0] corner_t [5];
    bit [15:0] corner_p [4];
    bit [15:0] rt, rp;
    rst = 1'b1; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    corner_t = '{16'd0, 16'hFFFF, 16'd27898, 16'h5555, 16'hAAAA};
    corner_p = '{16'd0, 16'hFFFF, 16'd23843, 16'h5A5A};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed corners on the typical calibration
    load_cal(0);
    foreach (corner_t[i])
      foreach (corner_p[k]) send_reading(corner_t[i], corner_p[k]);
    drain();

    // random phases across calibration sets and idle patterns
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      load_cal(ph < 4 ? ph : (ph % 2 ? 5 : 4));
      for (int n = 0; n < 113; n++) begin
        // mostly plausible sensor readings, some fully random
        if ($urandom_range(3) != 0) begin
          rt = 16'($urandom_range(32000, 20000));
          rp = 16'($urandom_range(42000, 15000));
        end else begin
          rt = 16'($urandom);
          rp = 16'($urandom);
        end
        send_reading(rt, rp);
      end
      drain();
    end

    recv_stall_pct = 0;
    if (checker_h.mismatches == 0 && checker_h.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #6000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
